FILE: hw/rtl/fhlq_pkg.sv
package fhlq_pkg;

  localparam logic [1:0] MODE_LOCK   = 2'd0;
  localparam logic [1:0] MODE_UNLOCK = 2'd1;
  localparam logic [1:0] MODE_TRY    = 2'd2;

  localparam logic [2:0] EBUSY        = 3'd2;
  localparam logic [2:0] STS_GRANTED  = 3'd0;
  localparam logic [2:0] STS_QUEUED   = 3'd1;
  localparam logic [2:0] STS_BUSY     = EBUSY;
  localparam logic [2:0] STS_RELEASED = 3'd3;
  localparam logic [2:0] STS_HANDOVER = 3'd4;
  localparam logic [2:0] STS_ERROR    = 3'd5;

  localparam int ID_W = 6;

  // Command queue between the front and the back.
  localparam int Q_DEPTH = 2;
  localparam int QAW     = 1;
  localparam int QCW     = 2;

  typedef struct packed {
    logic [1:0]      mode;
    logic [ID_W-1:0] requester_id;
  } in_item_t;

  typedef struct packed {
    logic [2:0]      status;
    logic            woken_valid;
    logic [ID_W-1:0] woken_id;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_LOCK,
    OP_UNLOCK,
    OP_TRY,
    OP_ERR
  } op_t;

  typedef struct packed {
    op_t             op;
    logic [ID_W-1:0] id;
  } cmd_t;

  typedef struct packed {
    logic vld;
    cmd_t cmd;
  } q_head_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } back_stat_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK
  } back_state_t;

endpackage

FILE: hw/rtl/fhlq_ram.sv
module fhlq_ram #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/fhlq_front.sv
module fhlq_front #(
  parameter int NUM_REQUESTERS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  fhlq_pkg::in_item_t  in_item,
  input  fhlq_pkg::back_stat_t stat,
  output fhlq_pkg::q_head_t   head
);

  fhlq_pkg::cmd_t                 q_mem_r [fhlq_pkg::Q_DEPTH];
  logic [fhlq_pkg::QAW-1:0]       wp_r, wp_nxt;
  logic [fhlq_pkg::QAW-1:0]       rp_r, rp_nxt;
  logic [fhlq_pkg::QCW-1:0]       cnt_r, cnt_nxt;
  logic                           full;
  logic                           accept;
  logic                           in_range;
  fhlq_pkg::cmd_t                 cmd;

  assign in_range = 32'(in_item.requester_id) < NUM_REQUESTERS;

  // Classify the transaction; out-of-range ids and unknown modes become errors.
  always_comb begin
    cmd.id = in_item.requester_id;
    case (in_item.mode)
      fhlq_pkg::MODE_LOCK:   cmd.op = fhlq_pkg::OP_LOCK;
      fhlq_pkg::MODE_UNLOCK: cmd.op = fhlq_pkg::OP_UNLOCK;
      fhlq_pkg::MODE_TRY:    cmd.op = fhlq_pkg::OP_TRY;
      default:               cmd.op = fhlq_pkg::OP_ERR;
    endcase
    if (!in_range) begin
      cmd.op = fhlq_pkg::OP_ERR;
    end
  end

  assign full   = cnt_r == fhlq_pkg::QCW'(fhlq_pkg::Q_DEPTH);
  assign busy   = full || stat.clearing;
  assign accept = start && !busy;

  always_comb begin
    wp_nxt  = accept ? wp_r + 1'b1 : wp_r;
    rp_nxt  = stat.pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r;
    if (accept && !stat.pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!accept && stat.pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_mem_r[wp_r] <= cmd;
    end
  end

  assign head.vld = cnt_r != '0;
  assign head.cmd = q_mem_r[rp_r];

endmodule

FILE: hw/rtl/fhlq_back.sv
module fhlq_back #(
  parameter int NUM_REQUESTERS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  fhlq_pkg::q_head_t    head,
  output fhlq_pkg::back_stat_t stat,
  output logic                 out_valid,
  output fhlq_pkg::out_item_t  out_item
);

  localparam int LW = $clog2(NUM_REQUESTERS + 1);
  localparam int IW = $clog2(NUM_REQUESTERS);
  localparam logic [LW-1:0] FREE = LW'(NUM_REQUESTERS);
  localparam logic [IW-1:0] LAST = IW'(NUM_REQUESTERS - 1);

  fhlq_pkg::back_state_t state_r, state_nxt;
  logic [LW-1:0]         tail_r, tail_nxt;
  logic [LW-1:0]         cur_r, cur_nxt;
  logic [LW-1:0]         id_r, id_nxt;
  logic [IW-1:0]         step_r, step_nxt;
  logic [IW-1:0]         clr_r, clr_nxt;
  logic                  out_valid_r, out_valid_nxt;
  fhlq_pkg::out_item_t   out_r, out_nxt;

  logic                  we;
  logic [IW-1:0]         waddr;
  logic [LW-1:0]         wdata;
  logic [IW-1:0]         raddr;
  logic [LW-1:0]         rdata;
  logic [LW-1:0]         cid;
  logic                  pop;
  logic                  found;
  logic                  dead_end;

  assign cid      = LW'(head.cmd.id);
  assign found    = rdata == id_r;
  assign dead_end = (rdata >= FREE) || (step_r == LAST);

  fhlq_ram #(
    .WIDTH (LW),
    .DEPTH (NUM_REQUESTERS)
  ) u_link (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fhlq_pkg::S_CLEAR: begin
        if (clr_r == LAST) begin
          state_nxt = fhlq_pkg::S_IDLE;
        end
      end
      fhlq_pkg::S_IDLE: begin
        if (head.vld && head.cmd.op == fhlq_pkg::OP_UNLOCK &&
            tail_r != FREE && tail_r != cid) begin
          state_nxt = fhlq_pkg::S_WALK;
        end
      end
      fhlq_pkg::S_WALK: begin
        if (found || dead_end) begin
          state_nxt = fhlq_pkg::S_IDLE;
        end
      end
      default: state_nxt = fhlq_pkg::S_CLEAR;
    endcase
  end

  always_comb begin
    tail_nxt      = tail_r;
    cur_nxt       = cur_r;
    id_nxt        = id_r;
    step_nxt      = step_r;
    clr_nxt       = clr_r;
    out_valid_nxt = 1'b0;
    out_nxt       = '0;
    we            = 1'b0;
    waddr         = IW'(cur_r);
    wdata         = FREE;
    raddr         = IW'(tail_r);
    pop           = 1'b0;
    case (state_r)
      fhlq_pkg::S_CLEAR: begin
        we      = 1'b1;
        waddr   = clr_r;
        clr_nxt = clr_r + 1'b1;
      end
      fhlq_pkg::S_IDLE: begin
        if (head.vld) begin
          pop           = 1'b1;
          out_valid_nxt = 1'b1;
          case (head.cmd.op)
            fhlq_pkg::OP_LOCK: begin
              if (tail_r == cid) begin
                out_nxt.status = fhlq_pkg::STS_ERROR;
              end else begin
                we       = 1'b1;
                waddr    = IW'(head.cmd.id);
                wdata    = tail_r;
                tail_nxt = cid;
                out_nxt.status = (tail_r == FREE) ? fhlq_pkg::STS_GRANTED
                                                  : fhlq_pkg::STS_QUEUED;
              end
            end
            fhlq_pkg::OP_TRY: begin
              if (tail_r != FREE) begin
                out_nxt.status = fhlq_pkg::STS_BUSY;
              end else begin
                tail_nxt       = cid;
                out_nxt.status = fhlq_pkg::STS_GRANTED;
              end
            end
            fhlq_pkg::OP_UNLOCK: begin
              if (tail_r == FREE) begin
                out_nxt.status = fhlq_pkg::STS_ERROR;
              end else if (tail_r == cid) begin
                tail_nxt       = FREE;
                out_nxt.status = fhlq_pkg::STS_RELEASED;
              end else begin
                // Start the walk at the newest entry; the result comes later.
                out_valid_nxt = 1'b0;
                raddr         = IW'(tail_r);
                cur_nxt       = tail_r;
                id_nxt        = cid;
                step_nxt      = '0;
              end
            end
            default: out_nxt.status = fhlq_pkg::STS_ERROR;
          endcase
        end
      end
      fhlq_pkg::S_WALK: begin
        // The read data holds the link of the entry at cur_r.
        if (found) begin
          out_valid_nxt       = 1'b1;
          we                  = 1'b1;
          waddr               = IW'(cur_r);
          out_nxt.status      = fhlq_pkg::STS_HANDOVER;
          out_nxt.woken_valid = 1'b1;
          out_nxt.woken_id    = fhlq_pkg::ID_W'(cur_r);
        end else if (dead_end) begin
          out_valid_nxt  = 1'b1;
          out_nxt.status = fhlq_pkg::STS_ERROR;
        end else begin
          cur_nxt  = rdata;
          raddr    = IW'(rdata);
          step_nxt = step_r + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fhlq_pkg::S_CLEAR;
      tail_r      <= FREE;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tail_r      <= tail_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    id_r   <= id_nxt;
    step_r <= step_nxt;
    out_r  <= out_nxt;
  end

  assign stat.pop      = pop;
  assign stat.clearing = state_r == fhlq_pkg::S_CLEAR;
  assign out_valid     = out_valid_r;
  assign out_item      = out_r;

`ifndef SYNTHESIS
  a_woken_is_handover: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.woken_valid |-> out_r.status == fhlq_pkg::STS_HANDOVER)
    else $error("woken waiter reported without a hand-over status");

  a_tail_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    tail_r <= FREE)
    else $error("lock word holds a value above the free mark");

  a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == fhlq_pkg::S_CLEAR |=> !out_valid_r)
    else $error("result issued during the link table clearing pass");

  a_walk_skips_self: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == fhlq_pkg::S_WALK |-> cur_r != id_r)
    else $error("walk reached the releasing requester itself");
`endif

endmodule

FILE: hw/rtl/fifo_handoff_lock_queue_core.sv
// Accepted transactions are queued; the back pops each and registers its result. An
// unlock that walks reads 1 to NUM_REQUESTERS links, failed walks included, and later
// transactions wait behind it. Throughput: one transaction per cycle while no walk or
// clearing pass holds the queue. Reset: the lock word becomes free and a clearing pass
// sets every link free, with busy high. The receiver cannot stall; out_valid lasts one cycle.
module fifo_handoff_lock_queue_core #(
  parameter int NUM_REQUESTERS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  fhlq_pkg::in_item_t  in_item,
  output logic                out_valid,
  output fhlq_pkg::out_item_t out_item
);

  fhlq_pkg::q_head_t    head;
  fhlq_pkg::back_stat_t stat;

  fhlq_front #(
    .NUM_REQUESTERS (NUM_REQUESTERS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_item (in_item),
    .stat    (stat),
    .head    (head)
  );

  fhlq_back #(
    .NUM_REQUESTERS (NUM_REQUESTERS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .stat      (stat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

FILE: tb/fifo_handoff_lock_queue_core_checker.sv
`timescale 1ns / 100ps

module fifo_handoff_lock_queue_core_checker
  import fhlq_pkg::*;
#(
  parameter int NUM_REQUESTERS = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  out_item_t out_item,
  output int        pending_results,
  output int        mismatches
);

  localparam logic [ID_W:0] LOCK_FREE = (ID_W + 1)'(NUM_REQUESTERS);

  // Shadow of the lock word and of the per-requester predecessor links.
  logic [ID_W:0] tail_id;
  logic [ID_W:0] waits_on [NUM_REQUESTERS];
  out_item_t     awaited_results [$];

  initial begin
    mismatches      = 0;
    pending_results = 0;
  end

  task automatic report(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatches++;
  endtask

  function automatic out_item_t lock_outcome(input in_item_t cmd);
    out_item_t     res;
    logic [ID_W:0] who;
    logic [ID_W:0] cur;
    logic [ID_W:0] nxt;
    bit            done;
    res        = '0;
    res.status = STS_ERROR;
    who        = {1'b0, cmd.requester_id};
    done       = 1'b0;
    if (who >= LOCK_FREE) return res;
    case (cmd.mode)
      MODE_LOCK: begin
        // A lock request by the current tail would link the tail to itself.
        if (tail_id != who) begin
          res.status = (tail_id == LOCK_FREE) ? STS_GRANTED : STS_QUEUED;
          waits_on[who[ID_W-1:0]] = tail_id;
          tail_id = who;
        end
      end
      MODE_TRY: begin
        if (tail_id == LOCK_FREE) begin
          tail_id    = who;
          res.status = STS_GRANTED;
        end else begin
          res.status = STS_BUSY;
        end
      end
      MODE_UNLOCK: begin
        if (tail_id == who) begin
          tail_id    = LOCK_FREE;
          res.status = STS_RELEASED;
        end else if (tail_id < LOCK_FREE) begin
          // Walk from the newest waiter toward the one queued right behind the owner.
          cur = tail_id;
          for (int step = 0; step < NUM_REQUESTERS; step++) begin
            if (done) break;
            nxt = waits_on[cur[ID_W-1:0]];
            if (nxt == who) begin
              waits_on[cur[ID_W-1:0]] = LOCK_FREE;
              res.status      = STS_HANDOVER;
              res.woken_valid = 1'b1;
              res.woken_id    = cur[ID_W-1:0];
              done            = 1'b1;
            end else if (nxt >= LOCK_FREE) begin
              done = 1'b1;
            end else begin
              cur = nxt;
            end
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      tail_id = LOCK_FREE;
      for (int i = 0; i < NUM_REQUESTERS; i++) waits_on[i] = LOCK_FREE;
      awaited_results.delete();
    end else begin
      if (out_valid) begin
        if (awaited_results.size() == 0) begin
          report($sformatf("result (status %0d) with no transaction outstanding",
                           out_item.status));
        end else begin
          want = awaited_results.pop_front();
          if (out_item.status !== want.status)
            report($sformatf("status %0d, expected %0d", out_item.status, want.status));
          if (out_item.woken_valid !== want.woken_valid)
            report($sformatf("woken_valid %0d, expected %0d",
                             out_item.woken_valid, want.woken_valid));
          if (out_item.woken_id !== want.woken_id)
            report($sformatf("woken_id %0d, expected %0d", out_item.woken_id, want.woken_id));
        end
      end
      if (start && !busy) awaited_results.push_back(lock_outcome(in_item));
    end
    pending_results <= awaited_results.size();
  end

endmodule

FILE: tb/fifo_handoff_lock_queue_core_test.sv
`timescale 1ns / 100ps

module fifo_handoff_lock_queue_core_test;
  import fhlq_pkg::*;

  localparam int NUM_REQ       = 64;
  localparam logic [1:0] MODE_BAD = 2'd3;
  localparam int ITEM_TARGET   = 900;
  localparam int CALM_AFTER    = 760;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 100;

  logic      clk     = 1'b0;
  logic      rst_n   = 1'b0;
  logic      start   = 1'b0;
  in_item_t  in_item = '0;
  logic      busy;
  logic      out_valid;
  out_item_t out_item;
  int        pending_results;
  int        mismatches;
  int        items_sent = 0;
  int        cycle_count = 0;
  bit        allow_idle = 1'b1;

  fifo_handoff_lock_queue_core #(.NUM_REQUESTERS(NUM_REQ)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  fifo_handoff_lock_queue_core_checker #(.NUM_REQUESTERS(NUM_REQ)) lock_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_item        (in_item),
    .out_valid      (out_valid),
    .out_item       (out_item),
    .pending_results(pending_results),
    .mismatches     (mismatches)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("fifo_handoff_lock_queue_core_test NOT OK");
      $finish;
    end
  end

  // Presents one transaction and returns at the edge that accepts it. start stays high
  // unless an idle burst comes first, so back-to-back transactions need no extra step.
  task automatic issue(input logic [1:0] mode, input logic [ID_W-1:0] id);
    int gap;
    gap = 0;
    if (allow_idle && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 15);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start                <= 1'b1;
    in_item.mode         <= mode;
    in_item.requester_id <= id;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  // Orderly use of the lock: distinct requesters queue up, the owner releases in turn,
  // and others try the lock while it is held. The lock is free again at the end.
  task automatic orderly_episode();
    int ids [NUM_REQ];
    int owners [$];
    int n, added, j, tmp;
    for (int i = 0; i < NUM_REQ; i++) ids[i] = i;
    for (int i = NUM_REQ - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = ids[i];
      ids[i] = ids[j];
      ids[j] = tmp;
    end
    n = ($urandom_range(0, 15) == 0) ? $urandom_range(7, NUM_REQ) : $urandom_range(1, 6);
    added = 0;
    while (added < n || owners.size() > 0) begin
      if (owners.size() > 0 && $urandom_range(0, 5) == 0) begin
        issue(MODE_TRY, ID_W'($urandom_range(0, NUM_REQ - 1)));
      end else if (added < n && (owners.size() == 0 || $urandom_range(0, 2) != 0)) begin
        if (owners.size() == 0 && $urandom_range(0, 1) == 0)
          issue(MODE_TRY, ID_W'(ids[added]));
        else
          issue(MODE_LOCK, ID_W'(ids[added]));
        owners.push_back(ids[added]);
        added++;
      end else begin
        issue(MODE_UNLOCK, ID_W'(owners.pop_front()));
      end
    end
  endtask

  // Random transactions, including repeated locks that tie the links into loops.
  // Afterwards every id touched unlocks once; the tail is among them and its unlock
  // frees the lock, since unlocks by other ids never move the tail.
  task automatic noise_episode();
    logic [NUM_REQ-1:0] touched;
    int k, id;
    touched = '0;
    k = $urandom_range(3, 15);
    repeat (k) begin
      id = $urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom_range(0, NUM_REQ - 1);
      touched[id] = 1'b1;
      issue(2'($urandom_range(0, 3)), ID_W'(id));
    end
    for (int i = 0; i < NUM_REQ; i++)
      if (touched[i]) issue(MODE_UNLOCK, ID_W'(i));
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part; the lock is free again when it ends.
    issue(MODE_UNLOCK, 6'd0);   // unlock of a free lock
    issue(MODE_BAD, 6'd63);     // unknown mode
    issue(MODE_TRY, 6'd63);     // granted
    issue(MODE_TRY, 6'd0);      // busy
    issue(MODE_LOCK, 6'd63);    // lock by the tail
    issue(MODE_LOCK, 6'd0);     // queued behind 63
    issue(MODE_LOCK, 6'd42);    // queued behind 0
    issue(MODE_UNLOCK, 6'd21);  // walk runs off the end of the chain
    issue(MODE_UNLOCK, 6'd63);  // hands over to 0
    issue(MODE_UNLOCK, 6'd0);   // hands over to 42
    issue(MODE_UNLOCK, 6'd42);  // released
    issue(MODE_LOCK, 6'd21);    // granted
    issue(MODE_LOCK, 6'd0);
    issue(MODE_LOCK, 6'd21);    // 21 and 0 now point at each other
    issue(MODE_UNLOCK, 6'd5);   // walk goes around the loop and gives up
    issue(MODE_UNLOCK, 6'd21);  // released
    issue(MODE_BAD, 6'd0);
    issue(MODE_BAD, 6'd42);
    issue(MODE_LOCK, 6'd63);
    issue(MODE_UNLOCK, 6'd63);

    while (items_sent < ITEM_TARGET) begin
      allow_idle = (items_sent < CALM_AFTER) && ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 3) == 0) noise_episode();
      else orderly_episode();
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("fifo_handoff_lock_queue_core_test OK");
    end else begin
      $display("fifo_handoff_lock_queue_core_test NOT OK");
    end
    $finish;
  end

endmodule
